@@ rtl/core/bfcw_pkg.sv @@
package bfcw_pkg;

  localparam int MaxNodes  = 1024;
  localparam int MaxEdges  = 4096;
  localparam int BusyBits  = 8;
  localparam int NodeBits  = $clog2(MaxNodes);
  localparam int EdgeBits  = $clog2(MaxEdges);
  localparam int CostBits  = 35;
  localparam int WeightBits = 3 * BusyBits + 2;
  localparam int MinKnownCost = 3;

  typedef enum logic [2:0] {
    REQ_CLEAR = 3'd0,
    REQ_BUSY  = 3'd1,
    REQ_ROAD  = 3'd2,
    REQ_RUN   = 3'd3,
    REQ_QUERY = 3'd4
  } req_e;

  typedef struct packed {
    logic [2:0] req_type;
    logic [9:0] junction_a;
    logic [9:0] junction_b;
    logic [7:0] busyness;
  } bfcw_in_t;

  typedef struct packed {
    logic        status;
    logic        answer_known;
    logic [33:0] path_cost;
    logic        negative_cycle;
  } bfcw_out_t;

  // road entry: source, destination, signed weight
  typedef struct packed {
    logic [NodeBits-1:0]          src;
    logic [NodeBits-1:0]          dst;
    logic signed [WeightBits-1:0] weight;
  } road_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CLR,
    ST_BUSY_RD,
    ST_BUSY_WT,
    ST_ROAD_MUL1,
    ST_ROAD_MUL2,
    ST_RUN_INIT,
    ST_RUN_WIPE,
    ST_RUN_ERD,
    ST_RUN_SRD,
    ST_RUN_DRD,
    ST_RUN_CMP,
    ST_Q_RD,
    ST_Q_WT,
    ST_DONE
  } state_e;

endpackage

@@ rtl/core/bellman_ford_cubic_weight_paths_core.sv @@
// Shortest-path engine over cubic-weight roads, single source junction 1.
// Input channel: a command in req_i is taken at a clock edge with start_i high
// and busy_o low. Exactly one result per command appears on res_o for one
// cycle, marked by done_o; the receiver cannot stall and must take it then.
// Commands: clear, load busyness, load road, run, query.
// Run: a sweep marks every cost unreachable and seeds junction 1, then passes
// are made over the roads, N for N >= 1 junctions and 1 for none; each road is
// handled by an edge read, a source cost read, a destination cost read and a
// compare/write, and each pass ends with a wrap step.
// busy_o is high from acceptance through the done_o cycle, so the next
// command is taken in the cycle after done_o at the earliest.
// After reset all counts are zero, costs read unreachable until the first run
// and the cycle flag is low; the busyness and road memories hold garbage
// until loaded.
module bellman_ford_cubic_weight_paths_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  bfcw_pkg::bfcw_in_t  req_i,
  output logic                busy_o,
  output logic                done_o,
  output bfcw_pkg::bfcw_out_t res_o
);
  import bfcw_pkg::*;

  state_e state_q, state_d;
  bfcw_in_t req_q, req_d;
  logic [NodeBits:0]   jcnt_q, jcnt_d;
  logic [EdgeBits:0]   ecnt_q, ecnt_d;
  logic                flag_q, flag_d;
  logic                costs_live_q, costs_live_d;
  logic [EdgeBits:0]   eidx_q, eidx_d;
  logic [NodeBits:0]   round_q, round_d;
  logic [NodeBits-1:0] wipe_q, wipe_d;
  logic                check_q, check_d;
  bfcw_out_t           res_q, res_d;
  logic                done_q, done_d;
  road_t               road_q, road_d;
  logic signed [CostBits-1:0] scost_q, scost_d;
  logic                sreach_q, sreach_d;
  logic signed [BusyBits+1:0] diff_q, diff_d;
  logic signed [2*BusyBits+3:0] sq_q, sq_d;
  logic [BusyBits-1:0] bsrc_q, bsrc_d;

  // busyness memory
  logic [BusyBits-1:0] busy_mem [MaxNodes];
  logic [BusyBits-1:0] busy_rd_q;
  logic                busy_we;
  logic [NodeBits-1:0] busy_addr;

  always_ff @(posedge clk_i) begin
    if (busy_we) begin
      busy_mem[busy_addr] <= req_q.busyness[BusyBits-1:0];
    end
    busy_rd_q <= busy_mem[busy_addr];
  end

  // road memory
  road_t               edge_mem [MaxEdges];
  road_t               edge_rd_q;
  logic                edge_we;
  logic [EdgeBits-1:0] edge_addr;
  road_t               edge_wd;

  always_ff @(posedge clk_i) begin
    if (edge_we) begin
      edge_mem[edge_addr] <= edge_wd;
    end
    edge_rd_q <= edge_mem[edge_addr];
  end

  // cost memory
  logic                       c_we, c_reach, c_wreach;
  logic [NodeBits-1:0]        c_raddr, c_waddr;
  logic signed [CostBits-1:0] c_rcost, c_wcost;

  bfcw_cost_mem u_cost (
    .clk_i,
    .raddr_i(c_raddr), .rreach_o(c_reach), .rcost_o(c_rcost),
    .we_i(c_we), .waddr_i(c_waddr), .wreach_i(c_wreach), .wcost_i(c_wcost)
  );

  logic ja_ok, jb_ok;
  assign ja_ok = (req_q.junction_a != '0) && ({1'b0, req_q.junction_a} <= jcnt_q);
  assign jb_ok = (req_q.junction_b != '0) && ({1'b0, req_q.junction_b} <= jcnt_q);

  logic signed [CostBits-1:0] cand;
  assign cand = scost_q + CostBits'(road_q.weight);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      jcnt_q       <= '0;
      ecnt_q       <= '0;
      flag_q       <= 1'b0;
      costs_live_q <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      jcnt_q       <= jcnt_d;
      ecnt_q       <= ecnt_d;
      flag_q       <= flag_d;
      costs_live_q <= costs_live_d;
      done_q       <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    eidx_q   <= eidx_d;
    round_q  <= round_d;
    wipe_q   <= wipe_d;
    check_q  <= check_d;
    res_q    <= res_d;
    road_q   <= road_d;
    scost_q  <= scost_d;
    sreach_q <= sreach_d;
    diff_q   <= diff_d;
    sq_q     <= sq_d;
    bsrc_q   <= bsrc_d;
  end

  // command sequencer
  always_comb begin
    state_d = state_q;
    req_d = req_q; jcnt_d = jcnt_q; ecnt_d = ecnt_q; flag_d = flag_q;
    costs_live_d = costs_live_q;
    eidx_d = eidx_q; round_d = round_q; wipe_d = wipe_q; check_d = check_q;
    res_d = res_q; done_d = 1'b0; road_d = road_q; scost_d = scost_q;
    sreach_d = sreach_q; diff_d = diff_q; sq_d = sq_q; bsrc_d = bsrc_q;
    busy_we = 1'b0; busy_addr = req_q.junction_a[NodeBits-1:0];
    edge_we = 1'b0; edge_addr = eidx_q[EdgeBits-1:0]; edge_wd = road_q;
    c_we = 1'b0; c_raddr = req_q.junction_a[NodeBits-1:0];
    c_waddr = road_q.dst; c_wreach = 1'b1; c_wcost = cand;
    case (state_q)
      ST_IDLE: begin
        // done_q still high means busy_o is high
        if (start_i && !done_q) begin
          req_d = req_i;
          res_d = '0;
          case (req_i.req_type)
            REQ_CLEAR: state_d = ST_CLR;
            REQ_BUSY:  state_d = ST_BUSY_RD;
            REQ_ROAD:  state_d = ST_BUSY_RD;
            REQ_RUN:   state_d = ST_RUN_INIT;
            REQ_QUERY: state_d = ST_Q_RD;
            default:   state_d = ST_DONE;
          endcase
        end
      end
      ST_CLR: begin
        // costs read unreachable until the next run sweeps the store
        jcnt_d = '0; ecnt_d = '0; flag_d = 1'b0; costs_live_d = 1'b0;
        state_d = ST_DONE;
      end
      ST_BUSY_RD: begin
        if (req_q.req_type == REQ_BUSY) begin
          if (jcnt_q + 1'b1 >= (NodeBits+1)'(MaxNodes)) begin
            res_d.status = 1'b1;
          end else begin
            busy_we = 1'b1;
            busy_addr = NodeBits'(jcnt_q + 1'b1);
            jcnt_d = jcnt_q + 1'b1;
          end
          state_d = ST_DONE;
        end else if (ecnt_q >= (EdgeBits+1)'(MaxEdges) || !ja_ok || !jb_ok) begin
          res_d.status = 1'b1;
          state_d = ST_DONE;
        end else begin
          busy_addr = req_q.junction_a[NodeBits-1:0];
          state_d = ST_BUSY_WT;
        end
      end
      ST_BUSY_WT: begin
        bsrc_d = busy_rd_q;
        busy_addr = req_q.junction_b[NodeBits-1:0];
        state_d = ST_ROAD_MUL1;
      end
      ST_ROAD_MUL1: begin
        diff_d = $signed({2'b00, busy_rd_q}) - $signed({2'b00, bsrc_q});
        state_d = ST_ROAD_MUL2;
      end
      ST_ROAD_MUL2: begin
        sq_d = (2*BusyBits+4)'(diff_q * diff_q);
        road_d.src = req_q.junction_a[NodeBits-1:0];
        road_d.dst = req_q.junction_b[NodeBits-1:0];
        // weight is finished and written in the shared write-back state
        state_d = ST_Q_WT;
        check_d = 1'b1;
      end
      ST_Q_WT: begin
        if (check_q) begin
          // finish road: cube and store
          edge_wd = road_q;
          edge_wd.weight = WeightBits'(sq_q * diff_q);
          edge_we = 1'b1;
          edge_addr = ecnt_q[EdgeBits-1:0];
          ecnt_d = ecnt_q + 1'b1;
        end else begin
          res_d.negative_cycle = flag_q;
          if (!ja_ok) begin
            res_d.status = 1'b1;
          end else if (costs_live_q && c_reach && !flag_q &&
                       c_rcost >= CostBits'(MinKnownCost)) begin
            res_d.answer_known = 1'b1;
            res_d.path_cost = c_rcost[33:0];
          end
        end
        state_d = ST_DONE;
      end
      ST_RUN_INIT: begin
        flag_d = 1'b0; costs_live_d = 1'b1;
        eidx_d = '0; round_d = (NodeBits+1)'(1); wipe_d = '0;
        check_d = (jcnt_q <= (NodeBits+1)'(1));
        state_d = ST_RUN_WIPE;
      end
      ST_RUN_WIPE: begin
        // every junction unreachable, junction 1 seeded at cost 0
        c_we = 1'b1;
        c_waddr = wipe_q;
        c_wreach = (wipe_q == NodeBits'(1));
        c_wcost = '0;
        wipe_d = wipe_q + 1'b1;
        if (wipe_q == NodeBits'(MaxNodes - 1)) begin
          state_d = ST_RUN_ERD;
        end
      end
      ST_RUN_ERD: begin
        if (eidx_q == ecnt_q) begin
          eidx_d = '0;
          if (check_q) begin
            res_d.negative_cycle = flag_q;
            state_d = ST_DONE;
          end else begin
            round_d = round_q + 1'b1;
            check_d = (round_q + 1'b1 >= jcnt_q);
          end
        end else begin
          edge_addr = eidx_q[EdgeBits-1:0];
          state_d = ST_RUN_SRD;
        end
      end
      ST_RUN_SRD: begin
        road_d = edge_rd_q;
        c_raddr = edge_rd_q.src;
        state_d = ST_RUN_DRD;
      end
      ST_RUN_DRD: begin
        scost_d = c_rcost; sreach_d = c_reach;
        c_raddr = road_q.dst;
        state_d = ST_RUN_CMP;
      end
      ST_RUN_CMP: begin
        if (sreach_q && (!c_reach || cand < c_rcost)) begin
          if (check_q) flag_d = 1'b1;
          else c_we = 1'b1;
        end
        eidx_d = eidx_q + 1'b1;
        state_d = ST_RUN_ERD;
      end
      ST_Q_RD: begin
        check_d = 1'b0;
        c_raddr = req_q.junction_a[NodeBits-1:0];
        state_d = ST_Q_WT;
      end
      ST_DONE: begin
        done_d = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy_o = (state_q != ST_IDLE) || done_q;
  assign done_o = done_q;
  assign res_o  = res_q;

  // assertions
  a_done_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held two cycles");
  a_busy_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o) else $error("done without busy");
  a_ecnt_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ecnt_q <= (EdgeBits+1)'(MaxEdges)) else $error("edge count overflow");
  a_jcnt_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    jcnt_q < (NodeBits+1)'(MaxNodes)) else $error("junction count overflow");
endmodule

@@ rtl/core/bfcw_cost_mem.sv @@
// cost store: one reachable bit and one signed cost per junction
// synchronous memory, one read port and one write port, registered read
module bfcw_cost_mem (
  input  logic                                 clk_i,
  input  logic [bfcw_pkg::NodeBits-1:0]        raddr_i,
  output logic                                 rreach_o,
  output logic signed [bfcw_pkg::CostBits-1:0] rcost_o,
  input  logic                                 we_i,
  input  logic [bfcw_pkg::NodeBits-1:0]        waddr_i,
  input  logic                                 wreach_i,
  input  logic signed [bfcw_pkg::CostBits-1:0] wcost_i
);
  import bfcw_pkg::*;

  // entry layout: reachable bit above the cost
  logic [CostBits:0] mem [MaxNodes];
  logic [CostBits:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= {wreach_i, wcost_i};
    end
    rd_q <= mem[raddr_i];
  end

  assign rreach_o = rd_q[CostBits];
  assign rcost_o  = rd_q[CostBits-1:0];
endmodule

@@ sim/bellman_ford_cubic_weight_paths_checker.sv @@
module bellman_ford_cubic_weight_paths_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_i,
  input  bfcw_pkg::bfcw_in_t  req_i,
  input  logic                done_i,
  input  bfcw_pkg::bfcw_out_t res_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  import bfcw_pkg::*;

  // shadow copy of the path engine state
  logic [7:0] busy_mem [MaxNodes];
  int         road_src [MaxEdges];
  int         road_dst [MaxEdges];
  longint     road_wgt [MaxEdges];
  longint     path_len [MaxNodes];
  bit         path_hit [MaxNodes];
  int         node_cnt;
  int         road_cnt;
  bit         loop_flag;

  bfcw_out_t answer_q [$];

  function automatic bit node_valid(int j);
    return j >= 1 && j <= node_cnt && j < MaxNodes;
  endfunction

  function automatic void forget_paths();
    foreach (path_len[i]) begin
      path_len[i] = 0;
      path_hit[i] = 1'b0;
    end
  endfunction

  // relaxation rounds then the final negative loop scan
  function automatic void relax_all();
    longint c;
    forget_paths();
    path_hit[1] = 1'b1;
    loop_flag = 1'b0;
    for (int rnd = 1; rnd < node_cnt; rnd++) begin
      for (int e = 0; e < road_cnt; e++) begin
        if (path_hit[road_src[e]]) begin
          c = path_len[road_src[e]] + road_wgt[e];
          if (!path_hit[road_dst[e]] || c < path_len[road_dst[e]]) begin
            path_len[road_dst[e]] = c;
            path_hit[road_dst[e]] = 1'b1;
          end
        end
      end
    end
    for (int e = 0; e < road_cnt; e++) begin
      if (path_hit[road_src[e]] && (!path_hit[road_dst[e]] ||
          path_len[road_src[e]] + road_wgt[e] < path_len[road_dst[e]]))
        loop_flag = 1'b1;
    end
  endfunction

  function automatic bfcw_out_t predict_answer(bfcw_in_t r);
    bfcw_out_t o;
    int ja;
    int jb;
    longint d;
    o = '0;
    ja = int'(r.junction_a);
    jb = int'(r.junction_b);
    case (r.req_type)
      REQ_CLEAR: begin
        node_cnt = 0;
        road_cnt = 0;
        loop_flag = 1'b0;
        forget_paths();
      end
      REQ_BUSY: begin
        if (node_cnt + 1 >= MaxNodes) begin
          o.status = 1'b1;
        end else begin
          node_cnt++;
          busy_mem[node_cnt] = r.busyness;
        end
      end
      REQ_ROAD: begin
        if (road_cnt >= MaxEdges || !node_valid(ja) || !node_valid(jb)) begin
          o.status = 1'b1;
        end else begin
          d = longint'(busy_mem[jb]) - longint'(busy_mem[ja]);
          road_src[road_cnt] = ja;
          road_dst[road_cnt] = jb;
          road_wgt[road_cnt] = d * d * d;
          road_cnt++;
        end
      end
      REQ_RUN: begin
        relax_all();
        o.negative_cycle = loop_flag;
      end
      REQ_QUERY: begin
        o.negative_cycle = loop_flag;
        if (!node_valid(ja)) begin
          o.status = 1'b1;
        end else if (path_hit[ja] && !loop_flag && path_len[ja] >= MinKnownCost) begin
          o.answer_known = 1'b1;
          o.path_cost = path_len[ja][33:0];
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  task automatic report(string field, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
    fail_count_o++;
  endtask

  // predict on each accepted transaction, compare each result
  always @(posedge clk_i or negedge rst_ni) begin
    bfcw_out_t want;
    if (!rst_ni) begin
      answer_q.delete();
      fail_count_o = 0;
      pending_o = 0;
      node_cnt = 0;
      road_cnt = 0;
      loop_flag = 1'b0;
      forget_paths();
    end else begin
      if (done_i) begin
        if (answer_q.size() == 0) begin
          report("unexpected result", 0, 0);
        end else begin
          want = answer_q.pop_front();
          if (res_i.status !== want.status)
            report("status", res_i.status, want.status);
          if (res_i.answer_known !== want.answer_known)
            report("answer_known", res_i.answer_known, want.answer_known);
          if (res_i.path_cost !== want.path_cost)
            report("path_cost", res_i.path_cost, want.path_cost);
          if (res_i.negative_cycle !== want.negative_cycle)
            report("negative_cycle", res_i.negative_cycle, want.negative_cycle);
        end
      end
      if (start_i && !busy_i)
        answer_q = {answer_q, predict_answer(req_i)};
      pending_o = answer_q.size();
    end
  end

endmodule

@@ sim/bellman_ford_cubic_weight_paths_core_test.sv @@
module bellman_ford_cubic_weight_paths_core_test;
  import bfcw_pkg::*;

  logic      clk_i;
  logic      rst_ni;
  logic      start_i;
  bfcw_in_t  req_i;
  logic      busy_o;
  logic      done_o;
  bfcw_out_t res_o;
  int        fail_count;
  int        pending;
  int        idle_pct;

  bellman_ford_cubic_weight_paths_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .req_i  (req_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .res_o  (res_o)
  );

  bellman_ford_cubic_weight_paths_checker u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_i      (busy_o),
    .req_i       (req_i),
    .done_i      (done_o),
    .res_i       (res_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // hard stop for a hung run
  initial begin
    #(20 * 3000000);
    $display("Verification failed");
    $finish;
  end

  // one transaction, with an optional idle gap ahead of it
  task automatic issue(req_e kind, int ja, int jb, int busy);
    if ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      repeat ($urandom_range(0, 4)) @(negedge clk_i);
    end
    @(negedge clk_i);
    start_i <= 1'b1;
    req_i.req_type <= kind;
    req_i.junction_a <= 10'(ja);
    req_i.junction_b <= 10'(jb);
    req_i.busyness <= 8'(busy);
    while (busy_o) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic drain();
    @(negedge clk_i);
    start_i <= 1'b0;
    wait (pending == 0);
  endtask

  function automatic int pick_node(int n);
    case ($urandom_range(0, 19))
      0: return 0;
      1: return n + 1;
      2: return 1023;
      3: return $urandom_range(0, 1023);
      default: return $urandom_range(1, n);
    endcase
  endfunction

  // random case: clear, loads, roads, optional early query, run, queries; junctions may be out of range
  task automatic random_case();
    int n;
    int m;
    n = $urandom_range(1, 7);
    m = $urandom_range(0, 8);
    issue(REQ_CLEAR, $urandom, $urandom, $urandom);
    for (int i = 0; i < n; i++)
      issue(REQ_BUSY, $urandom, $urandom,
            $urandom_range(0, 3) == 0 ? 255 * $urandom_range(0, 1) : $urandom_range(0, 255));
    for (int i = 0; i < m; i++)
      issue(REQ_ROAD, pick_node(n), pick_node(n), $urandom);
    if ($urandom_range(0, 3) == 0)
      issue(REQ_QUERY, pick_node(n), $urandom, $urandom);
    issue(REQ_RUN, $urandom, $urandom, $urandom);
    repeat ($urandom_range(1, 4))
      issue(REQ_QUERY, pick_node(n), $urandom, $urandom);
  endtask

  initial begin
    rst_ni = 1'b0;
    start_i = 1'b0;
    req_i = '0;
    idle_pct = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: small case with extreme busyness and range errors
    issue(REQ_QUERY, 1, 0, 0);
    issue(REQ_CLEAR, 0, 0, 0);
    issue(REQ_BUSY, 0, 0, 0);
    issue(REQ_BUSY, 0, 0, 255);
    issue(REQ_BUSY, 1023, 1023, 128);
    issue(REQ_QUERY, 2, 0, 0);
    issue(REQ_ROAD, 1, 2, 0);
    issue(REQ_ROAD, 2, 3, 0);
    issue(REQ_ROAD, 1, 3, 0);
    issue(REQ_ROAD, 0, 1, 0);
    issue(REQ_ROAD, 1, 4, 0);
    issue(REQ_RUN, 0, 0, 0);
    issue(REQ_QUERY, 1, 0, 0);
    issue(REQ_QUERY, 2, 0, 0);
    issue(REQ_QUERY, 3, 0, 0);
    issue(REQ_QUERY, 0, 0, 0);
    issue(REQ_QUERY, 4, 0, 0);
    issue(req_e'(3'd7), 1023, 1023, 255);
    // closing a negative loop 1 -> 3 -> 2 -> 1
    issue(REQ_ROAD, 3, 2, 0);
    issue(REQ_ROAD, 2, 1, 0);
    drain();
    issue(REQ_RUN, 0, 0, 0);
    issue(REQ_RUN, 0, 0, 0);
    issue(REQ_QUERY, 3, 0, 0);
    issue(REQ_CLEAR, 0, 0, 0);

    // random cases under each idle setting, with some noise
    for (int k = 0; k < 6; k++) begin
      case (k % 4)
        0: idle_pct = 0;
        1: idle_pct = 51;
        2: idle_pct = 7;
        default: idle_pct = 30;
      endcase
      random_case();
      repeat ($urandom_range(0, 3))
        issue(req_e'($urandom_range(0, 7)), $urandom, $urandom, $urandom);
      if (k == 3) drain();
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
